>>> rtl/ats_pkg.sv
// ---------------------------------------------------------------------------
// Assembly token scanner package
// Shared token kinds, character codes, result layout and keyword table.
// ---------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

   localparam int CH_W        = 8;
   localparam int KIND_W      = 6;
   localparam int OFFSET_W    = 16;
   localparam int WORD_CHARS  = 8;
   localparam int WORD_W      = WORD_CHARS * CH_W;

   localparam int KW_TABLE_SIZE = 40;
   localparam int KEYWORD_COUNT = 40;
   localparam int KW_LIMIT      = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_END     = 6'd0;
   localparam logic [KIND_W-1:0] KIND_COLON   = 6'd1;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd2;
   localparam logic [KIND_W-1:0] KIND_STRING  = 6'd3;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd4;
   localparam logic [KIND_W-1:0] KIND_SYMBOL  = 6'd5;
   localparam logic [KIND_W-1:0] KIND_KEYBASE = 6'd6;
   localparam logic [KIND_W-1:0] KIND_KEYLAST = 6'd45;
   localparam logic [KIND_W-1:0] KIND_BADCHAR = 6'd46;
   localparam logic [KIND_W-1:0] KIND_UNTERM  = 6'd47;

   localparam logic [CH_W-1:0] CH_NUL        = 8'h00;
   localparam logic [CH_W-1:0] CH_TAB        = 8'h09;
   localparam logic [CH_W-1:0] CH_LF         = 8'h0A;
   localparam logic [CH_W-1:0] CH_CR         = 8'h0D;
   localparam logic [CH_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CH_W-1:0] CH_QUOTE      = 8'h22;
   localparam logic [CH_W-1:0] CH_COMMA      = 8'h2C;
   localparam logic [CH_W-1:0] CH_DOT        = 8'h2E;
   localparam logic [CH_W-1:0] CH_DIGIT0     = 8'h30;
   localparam logic [CH_W-1:0] CH_EIGHT      = 8'h38;
   localparam logic [CH_W-1:0] CH_DIGIT9     = 8'h39;
   localparam logic [CH_W-1:0] CH_COLON      = 8'h3A;
   localparam logic [CH_W-1:0] CH_SEMI       = 8'h3B;
   localparam logic [CH_W-1:0] CH_UPPER_A    = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CH_W-1:0] CH_LOWER_A    = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z    = 8'h7A;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] start_offset;
      logic [OFFSET_W-1:0] token_length;
      logic                byte_suffix;
      logic                last;
   } tok_type;

   function automatic logic digit_char(input logic [CH_W-1:0] c);
      return (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
   endfunction

   function automatic logic word_char(input logic [CH_W-1:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             (c == CH_UNDERSCORE) || (c == CH_DOT);
   endfunction

   function automatic logic blank_char(input logic [CH_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   // Keyword text, right justified with the first character in the highest used byte.
   function automatic logic [WORD_W-1:0] kw_text(input int idx);
      logic [WORD_W-1:0] t;
      t = '0;
      case (idx)
         0:  t = "db";
         1:  t = "extern";
         2:  t = "global";
         3:  t = "section";
         4:  t = "text";
         5:  t = "data";
         6:  t = "st";
         7:  t = "ld";
         8:  t = "add";
         9:  t = "sub";
         10: t = "mul";
         11: t = "div";
         12: t = "mod";
         13: t = "inc";
         14: t = "dec";
         15: t = "push";
         16: t = "dup";
         17: t = "over";
         18: t = "swap";
         19: t = "drop";
         20: t = "rspush";
         21: t = "rspop";
         22: t = "rscopy";
         23: t = "rsdrop";
         24: t = "rsp";
         25: t = "rspset";
         26: t = "brk";
         27: t = "brkset";
         28: t = "eq";
         29: t = "gt";
         30: t = "lt";
         31: t = "or";
         32: t = "and";
         33: t = "not";
         34: t = "jmp";
         35: t = "jmpif";
         36: t = "halt";
         37: t = "syscall";
         38: t = "call";
         39: t = "ret";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input int idx);
      logic [WORD_W-1:0] t;
      logic [3:0]        n;
      t = kw_text(idx);
      n = '0;
      for (int j = 0; j < WORD_CHARS; j++) begin
         if (t[CH_W*j +: CH_W] != CH_NUL) begin
            n = 4'(j + 1);
         end
      end
      return n;
   endfunction

   // Keyword packed with the first character in the lowest byte.
   function automatic logic [WORD_W-1:0] kw_word(input int idx);
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] w;
      int                n;
      t = kw_text(idx);
      n = int'(kw_len(idx));
      w = '0;
      for (int j = 0; j < WORD_CHARS; j++) begin
         if (j < n) begin
            w[CH_W*j +: CH_W] = t[CH_W*(n-1-j) +: CH_W];
         end
      end
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ats_kw_match.sv
// ---------------------------------------------------------------------------
// Keyword matcher
// Compares the buffered identifier against every keyword in parallel and
// returns the keyword kind, or the symbol kind when nothing matches.
// ---------------------------------------------------------------------------
`default_nettype none

module ats_kw_match (
   input  wire logic [ats_pkg::WORD_W-1:0]   word,
   input  wire logic [ats_pkg::OFFSET_W-1:0] tok_len,
   input  wire logic [ats_pkg::CH_W-1:0]     final_char,
   output logic      [ats_pkg::KIND_W-1:0]   kind
);

   logic [ats_pkg::OFFSET_W-1:0] eff_len;
   logic                         len_ok;
   logic [ats_pkg::WORD_W-1:0]   byte_mask;
   logic [ats_pkg::WORD_W-1:0]   masked_word;
   logic [ats_pkg::KW_LIMIT-1:0] hit;

   always_comb begin
      eff_len = tok_len;
      if ((final_char == ats_pkg::CH_EIGHT) && (tok_len != '0)) begin
         eff_len = tok_len - 1'b1;
      end
      len_ok = (eff_len != '0) && (eff_len <= 16'd7) && (tok_len <= 16'd8);
      for (int j = 0; j < ats_pkg::WORD_CHARS; j++) begin
         byte_mask[ats_pkg::CH_W*j +: ats_pkg::CH_W] =
            (eff_len > 16'(j)) ? {ats_pkg::CH_W{1'b1}} : '0;
      end
      masked_word = word & byte_mask;
   end

   for (genvar i = 0; i < ats_pkg::KW_LIMIT; i++) begin : g_kw
      localparam logic [ats_pkg::WORD_W-1:0] KwWord = ats_pkg::kw_word(i);
      localparam logic [3:0]                 KwLen  = ats_pkg::kw_len(i);
      assign hit[i] = (eff_len == 16'(KwLen)) && (masked_word == KwWord);
   end

   always_comb begin
      kind = ats_pkg::KIND_SYMBOL;
      if (len_ok) begin
         for (int i = ats_pkg::KW_LIMIT - 1; i >= 0; i--) begin
            if (hit[i]) begin
               kind = ats_pkg::KIND_KEYBASE + ats_pkg::KIND_W'(i);
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/ats_out_queue.sv
// ---------------------------------------------------------------------------
// Token output queue
// Small queue that takes up to two tokens per cycle and hands out one while the reader is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module ats_out_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       push_count,
   input  wire ats_pkg::tok_type push_tok0,
   input  wire ats_pkg::tok_type push_tok1,
   output logic                  space,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output ats_pkg::tok_type      out_tok
);

   ats_pkg::tok_type                mem_ff [ats_pkg::QUEUE_DEPTH];
   logic [ats_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ats_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ats_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic [ats_pkg::QPTR_W-1:0]      wr_ptr_next;
   logic                            pop;

   assign out_valid   = (count_ff != '0);
   assign out_tok     = mem_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   assign space       = (count_ff <= ats_pkg::QCNT_W'(ats_pkg::QUEUE_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + ats_pkg::QPTR_W'(push_count);
      count_in  = count_ff + ats_pkg::QCNT_W'(push_count) - ats_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_tok0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_tok1;
      end
   end

endmodule

`default_nettype wire

>>> rtl/assembly_token_scanner_unit.sv
// ---------------------------------------------------------------------------
// Assembly token scanner
// Turns a stream of source characters into tokens with offset and length.
// ---------------------------------------------------------------------------
// Each request on the req_ channel carries one source character; a zero
// character ends the source, gives an end token and restarts offsets at 0.
// Each response on the rsp_ channel carries one token; rsp_tlast marks the
// final token caused by one character, since a character that ends a number
// or identifier can also give a token of its own.
// A character is taken into an input register, scanned from there once the
// queue has room for two tokens, and its tokens are written into a four-entry
// output queue that drives the rsp_ channel.
// One character is accepted per cycle while the queue has room for two
// tokens; a single response is handed out per cycle, so characters that give
// two tokens each run at the response rate.
// When the receiver stalls, the queue fills and req_tready drops; no token is
// lost. Reset empties the queue and returns the scanner to the start of a
// source at offset 0.
// ---------------------------------------------------------------------------
`default_nettype none

module assembly_token_scanner_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [15:0] start_offset, [31:16] token_length
   output logic      [6:0]  rsp_tuser,   // [5:0] kind, [6] byte_suffix
   output logic             rsp_tlast
);

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_COMMENT = 6'b000010,
      MODE_NUMBER  = 6'b000100,
      MODE_IDENT   = 6'b001000,
      MODE_STRING  = 6'b010000,
      MODE_HALT    = 6'b100000
   } mode_type;

   localparam logic [ats_pkg::OFFSET_W-1:0] OffsetMax = '1;

   logic                         in_vld_ff, in_vld_in;
   logic [ats_pkg::CH_W-1:0]     in_ch_ff;
   mode_type                     mode_ff, mode_in;
   logic [ats_pkg::OFFSET_W-1:0] pos_ff, pos_in;
   logic [ats_pkg::OFFSET_W-1:0] start_ff, start_in;
   logic [ats_pkg::OFFSET_W-1:0] len_ff, len_in;
   logic [ats_pkg::WORD_W-1:0]   word_ff, word_in;
   logic [ats_pkg::CH_W-1:0]     final_ff, final_in;

   logic                         space;
   logic                         advance;
   logic [ats_pkg::KIND_W-1:0]   word_kind;
   logic [ats_pkg::OFFSET_W-1:0] len_inc;
   ats_pkg::tok_type             res [2];
   logic [1:0]                   n_res;
   logic [1:0]                   push_count;
   ats_pkg::tok_type             out_tok;

   assign advance    = in_vld_ff && space;
   assign req_tready = !in_vld_ff || space;
   assign in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign push_count = advance ? n_res : 2'd0;
   assign len_inc    = (len_ff != OffsetMax) ? len_ff + 1'b1 : len_ff;

   ats_kw_match u_kw_match (
      .word       (word_ff),
      .tok_len    (len_ff),
      .final_char (final_ff),
      .kind       (word_kind)
   );

   always_comb begin
      logic                         dispatch;
      logic [ats_pkg::CH_W-1:0]     c;
      ats_pkg::tok_type             t;

      c        = in_ch_ff;
      dispatch = 1'b0;
      n_res    = 2'd0;
      res[0]   = '0;
      res[1]   = '0;
      t        = '0;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      word_in  = word_ff;
      final_in = final_ff;

      unique case (mode_ff)
         MODE_HALT: begin
            if (c == ats_pkg::CH_NUL) begin
               t = '{ats_pkg::KIND_END, pos_ff, '0, 1'b0, 1'b0};
               res[n_res[0]] = t;
               n_res = n_res + 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (c == ats_pkg::CH_NUL) begin
               t = '{ats_pkg::KIND_END, pos_ff, '0, 1'b0, 1'b0};
               res[n_res[0]] = t;
               n_res = n_res + 1'b1;
            end else if (c == ats_pkg::CH_LF) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (c == ats_pkg::CH_NUL) begin
               res[0] = '{ats_pkg::KIND_UNTERM, start_ff, len_ff, 1'b0, 1'b0};
               res[1] = '{ats_pkg::KIND_END, pos_ff, '0, 1'b0, 1'b0};
               n_res  = 2'd2;
            end else begin
               len_in = len_inc;
               if (c == ats_pkg::CH_QUOTE) begin
                  res[0]  = '{ats_pkg::KIND_STRING, start_ff, len_inc, 1'b0, 1'b0};
                  n_res   = 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_NUMBER: begin
            if (ats_pkg::digit_char(c)) begin
               len_in = len_inc;
            end else begin
               res[0]   = '{ats_pkg::KIND_NUMBER, start_ff, len_ff, 1'b0, 1'b0};
               n_res    = 2'd1;
               mode_in  = MODE_IDLE;
               dispatch = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (ats_pkg::word_char(c) || ats_pkg::digit_char(c)) begin
               if (len_ff < 16'(ats_pkg::WORD_CHARS)) begin
                  word_in[{len_ff[2:0], 3'b000} +: ats_pkg::CH_W] = c;
               end
               final_in = c;
               len_in   = len_inc;
            end else begin
               res[0]   = '{word_kind, start_ff, len_ff,
                            (final_ff == ats_pkg::CH_EIGHT), 1'b0};
               n_res    = 2'd1;
               mode_in  = MODE_IDLE;
               dispatch = 1'b1;
            end
         end
         default: begin
            mode_in  = MODE_IDLE;
            dispatch = 1'b1;
         end
      endcase

      if (dispatch) begin
         if (c == ats_pkg::CH_NUL) begin
            t = '{ats_pkg::KIND_END, pos_ff, '0, 1'b0, 1'b0};
            res[n_res[0]] = t;
            n_res = n_res + 1'b1;
         end else if (ats_pkg::blank_char(c)) begin
            mode_in = MODE_IDLE;
         end else if (c == ats_pkg::CH_SEMI) begin
            mode_in = MODE_COMMENT;
         end else if (c == ats_pkg::CH_COLON) begin
            t = '{ats_pkg::KIND_COLON, pos_ff, 16'd1, 1'b0, 1'b0};
            res[n_res[0]] = t;
            n_res = n_res + 1'b1;
         end else if (c == ats_pkg::CH_COMMA) begin
            t = '{ats_pkg::KIND_COMMA, pos_ff, 16'd1, 1'b0, 1'b0};
            res[n_res[0]] = t;
            n_res = n_res + 1'b1;
         end else if (c == ats_pkg::CH_QUOTE) begin
            mode_in  = MODE_STRING;
            start_in = pos_ff;
            len_in   = 16'd1;
         end else if (ats_pkg::digit_char(c)) begin
            mode_in  = MODE_NUMBER;
            start_in = pos_ff;
            len_in   = 16'd1;
         end else if (ats_pkg::word_char(c)) begin
            mode_in  = MODE_IDENT;
            start_in = pos_ff;
            len_in   = 16'd1;
            word_in  = ats_pkg::WORD_W'(c);
            final_in = c;
         end else begin
            t = '{ats_pkg::KIND_BADCHAR, pos_ff, 16'd1, 1'b0, 1'b0};
            res[n_res[0]] = t;
            n_res   = n_res + 1'b1;
            mode_in = MODE_HALT;
         end
      end

      if (c == ats_pkg::CH_NUL) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         word_in  = '0;
         final_in = '0;
      end else if (pos_ff != OffsetMax) begin
         pos_in = pos_ff + 1'b1;
      end

      if (n_res != 2'd0) begin
         res[n_res[1]].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         word_ff   <= '0;
         final_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (advance) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            word_ff  <= word_in;
            final_ff <= final_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff <= req_tdata;
      end
   end

   ats_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_tok0  (res[0]),
      .push_tok1  (res[1]),
      .space      (space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_tok    (out_tok)
   );

   assign rsp_tdata = {out_tok.token_length, out_tok.start_offset};
   assign rsp_tuser = {out_tok.byte_suffix, out_tok.kind};
   assign rsp_tlast = out_tok.last;

endmodule

`default_nettype wire

>>> rtl/ats_checker.sv
// ---------------------------------------------------------------------------
// Assembly token scanner checker
// Port-level assertions on the token stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ats_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [6:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // The queue is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response holds its token.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Token kinds stay within the defined range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[5:0] <= ats_pkg::KIND_UNTERM)
      else $error("token kind out of range");

   // Only symbols and keywords can carry the byte flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[6] |->
         rsp_tuser[5:0] >= ats_pkg::KIND_SYMBOL && rsp_tuser[5:0] <= ats_pkg::KIND_KEYLAST)
      else $error("byte flag on a token that is no word");

   // An end token is empty and always closes its character's tokens.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5:0] == ats_pkg::KIND_END |->
         rsp_tdata[31:16] == 16'd0 && rsp_tlast)
      else $error("malformed end token");

endmodule

bind assembly_token_scanner_unit ats_checker u_ats_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
